### hw/rtl/utf8_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared assertion wrappers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define UTF8SD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define UTF8SD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hw/rtl/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Types, constants and decode-step result shared by the decoder modules.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int HOLD_D    = 4;
    localparam int AVAIL_W   = 3;
    localparam int TDATA_O_W = 24;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [1:0]        CONT_TAG   = 2'b10;

    typedef enum logic {
        ST_IDLE,
        ST_DECODE
    } t_state;

    typedef enum logic [1:0] {
        ACT_EMIT,
        ACT_HOLD,
        ACT_TERM
    } t_act;

    typedef struct packed {
        t_act              act;
        logic [CP_W-1:0]   cp;
        logic              sub;
        logic [AVAIL_W-1:0] adv;
    } t_dec_res;

endpackage

### hw/rtl/utf8sd_decode_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Decodes the sequence at the head of the pending window: one code point,
// a replacement, a hold of an incomplete sequence, or the terminator.
// ----------------------------------------------------------------------------
module utf8sd_decode_unit
    import utf8sd_pkg::*;
(
    input  logic [HOLD_D-1:0][BYTE_W-1:0] i_win,
    input  logic [AVAIL_W-1:0]            i_avail,
    input  logic                          i_fin,
    output t_dec_res                      o_res
);

    logic [1:0]      extra;
    logic [AVAIL_W-1:0] seq_len;
    logic            bad_cont;
    logic [CP_W-1:0] cp;
    logic            bad_range;

    always_comb begin
        if ((i_win[0] & LEAD2_MASK) == LEAD2_CODE) begin
            extra = 2'd1;
        end else if ((i_win[0] & LEAD3_MASK) == LEAD3_CODE) begin
            extra = 2'd2;
        end else if ((i_win[0] & LEAD4_MASK) == LEAD4_CODE) begin
            extra = 2'd3;
        end else begin
            extra = 2'd0;
        end
        seq_len = {1'b0, extra} + 3'd1;

        bad_cont = (i_win[1][7:6] != CONT_TAG)
                || (extra >= 2'd2 && i_win[2][7:6] != CONT_TAG)
                || (extra == 2'd3 && i_win[3][7:6] != CONT_TAG);

        case (extra)
            2'd1:    cp = {10'd0, i_win[0][4:0], i_win[1][5:0]};
            2'd2:    cp = {5'd0, i_win[0][3:0], i_win[1][5:0], i_win[2][5:0]};
            2'd3:    cp = {i_win[0][2:0], i_win[1][5:0], i_win[2][5:0], i_win[3][5:0]};
            default: cp = {13'd0, i_win[0]};
        endcase

        bad_range = (extra == 2'd1 && cp < MIN_2BYTE)
                 || (extra == 2'd2 && cp < MIN_3BYTE)
                 || (extra == 2'd3 && cp < MIN_4BYTE)
                 || cp > MAX_SCALAR
                 || (cp >= SURR_LO && cp <= SURR_HI);

        o_res.act = ACT_EMIT;
        o_res.cp  = {13'd0, i_win[0]};
        o_res.sub = 1'b0;
        o_res.adv = 3'd1;

        if (i_win[0] == '0) begin
            o_res.act = ACT_TERM;
            o_res.cp  = '0;
        end else if (!i_win[0][7]) begin
            o_res.cp = {13'd0, i_win[0]};
        end else if (extra == 2'd0) begin
            o_res.cp  = REPLACEMENT;
            o_res.sub = 1'b1;
        end else if (seq_len > i_avail) begin
            if (i_fin) begin
                o_res.cp  = REPLACEMENT;
                o_res.sub = 1'b1;
                o_res.adv = i_avail;
            end else begin
                o_res.act = ACT_HOLD;
                o_res.adv = i_avail;
            end
        end else if (bad_cont) begin
            o_res.cp  = REPLACEMENT;
            o_res.sub = 1'b1;
        end else if (bad_range) begin
            o_res.cp  = REPLACEMENT;
            o_res.sub = 1'b1;
            o_res.adv = seq_len;
        end else begin
            o_res.cp  = cp;
            o_res.adv = seq_len;
        end
    end

endmodule

### hw/rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Byte-serial UTF-8 to code point decoder with U+FFFD replacement.
// ----------------------------------------------------------------------------
// Input channel s_*: one text byte per item in s_tdata, s_tlast marks the
// last byte of the text. Output channel m_*: one code point per item in
// m_tdata[20:0], m_tuser set on a replacement, m_tlast on the last result of
// the text or on the NUL terminator.
// An accepted byte is appended to the pending window; the sequencer then runs
// the shared decode step once per cycle over the window, each step giving at
// most one result, until the window is used up, a NUL ends the text or an
// incomplete sequence is held for the next byte. After the accept in ST_IDLE,
// each decode step in ST_DECODE gives a result or a hold; a bad continuation
// replays the bytes after the lead. The first result is registered by the first
// decode step after the accept. s_tready is low while a byte is being decoded.
// A full output register that is not taken stalls the decode step; the input
// then stays blocked until the byte's last result is registered.
// Reset drops any held bytes, clears the terminated flag and empties the
// output register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8sd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] text_byte
    input  logic                 s_tlast,   // final_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_O_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic                 m_tuser,   // [0] substituted
    output logic                 m_tlast    // end_of_text
);

`include "utf8_stream_decoder_defines.svh"

    t_state                        r_state, n_state;
    logic [HOLD_D-1:0][BYTE_W-1:0] r_pend, n_pend;
    logic [AVAIL_W-1:0]            r_avail, n_avail;
    logic                          r_fin, n_fin;
    logic                          r_term, n_term;
    logic                          r_m_valid, n_m_valid;
    logic [CP_W-1:0]               r_m_cp;
    logic                          r_m_sub;
    logic                          r_m_eot;
    logic                          out_free;
    logic                          load;
    logic                          eot;
    t_dec_res                      dec;

    utf8sd_decode_unit u_decode (
        .i_win   (r_pend),
        .i_avail (r_avail),
        .i_fin   (r_fin),
        .o_res   (dec)
    );

    assign out_free = !r_m_valid || m_tready;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_avail = r_avail;
        n_fin   = r_fin;
        n_term  = r_term;
        load    = 1'b0;
        eot     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (r_term) begin
                        if (s_tlast) begin
                            n_term = 1'b0;
                        end
                    end else begin
                        n_pend[r_avail[1:0]] = s_tdata;
                        n_avail              = r_avail + 3'd1;
                        n_fin                = s_tlast;
                        n_state              = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                if (out_free) begin
                    unique case (dec.act)
                        ACT_TERM: begin
                            load    = 1'b1;
                            eot     = 1'b1;
                            n_term  = !r_fin;
                            n_avail = '0;
                            n_state = ST_IDLE;
                        end
                        ACT_HOLD: begin
                            n_state = ST_IDLE;
                        end
                        ACT_EMIT: begin
                            load = 1'b1;
                            if (dec.adv == r_avail) begin
                                eot     = r_fin;
                                n_avail = '0;
                                n_state = ST_IDLE;
                            end else begin
                                n_avail = r_avail - dec.adv;
                                n_pend  = r_pend >> {dec.adv, 3'b000};
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load) begin
            n_m_valid = 1'b1;
        end else if (m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_avail   <= '0;
            r_term    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_avail   <= n_avail;
            r_term    <= n_term;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_fin  <= n_fin;
        if (load) begin
            r_m_cp  <= dec.cp;
            r_m_sub <= dec.sub;
            r_m_eot <= eot;
        end
    end

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(TDATA_O_W-CP_W){1'b0}}, r_m_cp};
    assign m_tuser  = r_m_sub;
    assign m_tlast  = r_m_eot;

    `UTF8SD_ASSERT(a_idle_holds_partial, s_tready |-> r_avail <= 3'd3, "idle window too full")
    `UTF8SD_ASSERT(a_decode_has_bytes, r_state == ST_DECODE |-> r_avail != 3'd0, "decode on empty window")
    `UTF8SD_ASSERT(a_term_no_hold, r_term |-> r_avail == 3'd0, "bytes held after terminator")
    `UTF8SD_ASSERT(a_sub_is_fffd, m_tvalid && m_tuser |-> m_tdata[CP_W-1:0] == REPLACEMENT, "substitute not U+FFFD")
    `UTF8SD_ASSERT(a_stall_blocks_decode, r_state == ST_DECODE && m_tvalid && !m_tready |=> r_avail == $past(r_avail), "decode advanced while stalled")

endmodule

### tb/utf8_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds directed and random UTF-8 text into the byte stream and checks each
// decoded code point, replacement flag and end-of-text flag against an
// in-bench decoder, with random idling on both sides, a long output hold-off
// and a drain pause.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
    import utf8sd_pkg::*;

    localparam int RANDOM_ITEMS    = 460;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            substituted;
        logic            end_of_text;
    } t_cp_result;

    class decode_scoreboard;
        t_cp_result        pending_cps[$];
        t_cp_result        step_cps[$];
        logic [BYTE_W-1:0] held[HOLD_D];
        int                held_n = 0;
        bit                term = 1'b0;
        int                mismatches = 0;

        function void emit(logic [CP_W-1:0] cp, logic sub, logic eot);
            t_cp_result r;
            r.code_point  = cp;
            r.substituted = sub;
            r.end_of_text = eot;
            step_cps.push_back(r);
        endfunction

        function int pending();
            return pending_cps.size();
        endfunction

        // Returns 1 when the byte is decoded, 0 when it is dropped after a NUL.
        function bit decode_byte(logic [BYTE_W-1:0] b, logic fin);
            logic [BYTE_W-1:0] win[HOLD_D];
            int                n;
            int                pos;
            int                extra;
            int                i;
            int unsigned       acc;
            bit                bad;
            bit                over;
            t_cp_result        r;
            if (term) begin
                if (fin) term = 1'b0;
                return 1'b0;
            end
            step_cps.delete();
            for (i = 0; i < held_n; i++) win[i] = held[i];
            win[held_n] = b;
            n = held_n + 1;
            held_n = 0;
            pos = 0;
            while (pos < n) begin
                if (win[pos] == 8'h00) begin
                    emit('0, 1'b0, 1'b1);
                    term = !fin;
                    break;
                end
                if (win[pos] < 8'h80) begin
                    emit(CP_W'(win[pos]), 1'b0, 1'b0);
                    pos++;
                    continue;
                end
                acc = 0;
                if ((win[pos] & LEAD2_MASK) == LEAD2_CODE) begin
                    extra = 1;
                    acc = 32'(win[pos] & 8'h1F);
                end else if ((win[pos] & LEAD3_MASK) == LEAD3_CODE) begin
                    extra = 2;
                    acc = 32'(win[pos] & 8'h0F);
                end else if ((win[pos] & LEAD4_MASK) == LEAD4_CODE) begin
                    extra = 3;
                    acc = 32'(win[pos] & 8'h07);
                end else begin
                    extra = 0;
                end
                if (extra == 0) begin
                    emit(REPLACEMENT, 1'b1, 1'b0);
                    pos++;
                    continue;
                end
                if (pos + 1 + extra > n) begin
                    if (fin) begin
                        emit(REPLACEMENT, 1'b1, 1'b0);
                    end else begin
                        for (i = 0; pos + i < n; i++) held[i] = win[pos + i];
                        held_n = n - pos;
                    end
                    break;
                end
                bad = 1'b0;
                for (i = 1; i <= extra && !bad; i++) begin
                    if (win[pos + i][7:6] != CONT_TAG) bad = 1'b1;
                    else acc = (acc << 6) | 32'(win[pos + i][5:0]);
                end
                if (bad) begin
                    emit(REPLACEMENT, 1'b1, 1'b0);
                    pos++;
                    continue;
                end
                over = (extra == 1 && acc < MIN_2BYTE) || (extra == 2 && acc < MIN_3BYTE) ||
                       (extra == 3 && acc < MIN_4BYTE) || acc > MAX_SCALAR ||
                       (acc >= SURR_LO && acc <= SURR_HI);
                if (over) emit(REPLACEMENT, 1'b1, 1'b0);
                else emit(CP_W'(acc), 1'b0, 1'b0);
                pos += 1 + extra;
            end
            if (fin && step_cps.size() > 0) begin
                r = step_cps.pop_back();
                r.end_of_text = 1'b1;
                step_cps.push_back(r);
            end
            if (fin) held_n = 0;
            foreach (step_cps[j]) pending_cps.push_back(step_cps[j]);
            return 1'b1;
        endfunction

        function void check_cp(logic [CP_W-1:0] cp, logic sub, logic eot);
            t_cp_result r;
            if (pending_cps.size() == 0) begin
                mismatches++;
                $error("unexpected item: code_point %h substituted %b end_of_text %b",
                       cp, sub, eot);
                return;
            end
            r = pending_cps.pop_front();
            if (r.code_point !== cp) begin
                mismatches++;
                $error("code_point expected %h actual %h", r.code_point, cp);
            end
            if (r.substituted !== sub) begin
                mismatches++;
                $error("substituted expected %b actual %b", r.substituted, sub);
            end
            if (r.end_of_text !== eot) begin
                mismatches++;
                $error("end_of_text expected %b actual %b", r.end_of_text, eot);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;   // [7:0] text_byte
    logic                 s_tlast;   // final_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_O_W-1:0] m_tdata;   // [20:0] code_point, [23:21] zero
    logic                 m_tuser;   // [0] substituted
    logic                 m_tlast;   // end_of_text

    decode_scoreboard  sb = new;
    logic [BYTE_W-1:0] text_q[$];
    int                fed_bytes = 0;
    bit                src_idle_on = 1'b1;
    bit                sink_idle_on = 1'b1;
    bit                hold_off_req = 1'b0;

    utf8_stream_decoder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_cp(m_tdata[CP_W-1:0], m_tuser, m_tlast);
    end

    function automatic void put_seq(int unsigned cp, int len);
        int i;
        case (len)
            1: text_q.push_back(8'(cp));
            2: text_q.push_back(LEAD2_CODE | 8'(cp >> 6));
            3: text_q.push_back(LEAD3_CODE | 8'(cp >> 12));
            default: text_q.push_back(LEAD4_CODE | 8'(cp >> 18));
        endcase
        for (i = len - 2; i >= 0; i--) text_q.push_back({CONT_TAG, 6'(cp >> (6 * i))});
    endfunction

    // Lead byte followed by fewer continuation bytes than it calls for.
    function automatic void put_partial();
        int extra;
        extra = $urandom_range(1, 3);
        case (extra)
            1: text_q.push_back(8'($urandom_range('hC0, 'hDF)));
            2: text_q.push_back(8'($urandom_range('hE0, 'hEF)));
            default: text_q.push_back(8'($urandom_range('hF0, 'hF7)));
        endcase
        repeat ($urandom_range(0, extra - 1)) text_q.push_back(8'($urandom_range('h80, 'hBF)));
    endfunction

    function automatic void gen_text();
        int          kind;
        int          len;
        int unsigned cp;
        text_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                len = $urandom_range(1, 4);
                case (len)
                    1: cp = $urandom_range(1, 'h7F);
                    2: cp = $urandom_range('h80, 'h7FF);
                    3: begin
                        cp = $urandom_range('h800, 'hFFFF);
                        if (cp >= SURR_LO && cp <= SURR_HI) cp -= 'h800;
                    end
                    default: cp = $urandom_range('h10000, MAX_SCALAR);
                endcase
                put_seq(cp, len);
            end else if (kind < 68) begin
                len = $urandom_range(2, 4);
                cp = len == 2 ? MIN_2BYTE : len == 3 ? MIN_3BYTE : MIN_4BYTE;
                put_seq($urandom_range(0, cp - 1), len);
            end else if (kind < 73) begin
                put_seq($urandom_range(SURR_LO, SURR_HI), 3);
            end else if (kind < 78) begin
                put_seq($urandom_range(MAX_SCALAR + 1, 'h1FFFFF), 4);
            end else if (kind < 86) begin
                put_partial();
                if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(1, 'h7F)));
                else text_q.push_back(8'($urandom_range('hC0, 'hFF)));
            end else if (kind < 93) begin
                if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range('h80, 'hBF)));
                else text_q.push_back(8'($urandom_range('hF8, 'hFF)));
            end else if (kind < 99) begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_q.push_back(8'h00);
            end
        end
        if ($urandom_range(0, 6) == 0) put_partial();
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        @(negedge i_clk);
        while (src_idle_on && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge i_clk); while (!s_tready);
        if (sb.decode_byte(b, fin)) fed_bytes++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : sink
        m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            m_tready <= !(sink_idle_on && $urandom_range(0, 99) < 14);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int start;
        int n;
        bit held_off;
        bit paused;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        held_off = 1'b0;
        paused   = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // valid 3-byte, max scalar, surrogate, overlong, above max, stray bytes, bad continuation
        text_q = '{8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80,
                   8'hC0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80, 8'h80, 8'hFF,
                   8'hF0, 8'h41, 8'h42, 8'h43};
        send_text();
        // truncated text
        text_q = '{8'hE2, 8'h82};
        send_text();
        // NUL ends the text, the rest is dropped
        text_q = '{8'h00, 8'h41, 8'h42};
        send_text();
        wait_drained();

        start = fed_bytes;
        while (fed_bytes - start < RANDOM_ITEMS) begin
            n = fed_bytes - start;
            if (!held_off && n >= 80) begin
                hold_off_req = 1'b1;
                held_off = 1'b1;
            end
            if (!paused && n >= 200) begin
                wait_drained();
                paused = 1'b1;
            end
            src_idle_on  = !(n >= 260 && n < 380);
            sink_idle_on = src_idle_on;
            gen_text();
            send_text();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_decode_unit.sv
hw/rtl/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
